// ===== rtl/core/pqr_pkg.sv =====
// Shared types and constants for the priority ready queue.
// Depends on nothing; used by pqr_cell and priority_ready_queue.
package pqr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int KEY_W       = 32;

    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_DEQ  = 2'd1;
    localparam logic [1:0] CMD_KILL = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [ID_W-1:0]  proc_id;
        logic [KEY_W-1:0] prio_key;
    } pqr_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  removed_id;
        logic [KEY_W-1:0] removed_key;
        logic             queue_empty;
    } pqr_rsp_t;

    typedef enum logic [1:0] {
        SEL_NEW,
        SEL_LEFT,
        SEL_RIGHT
    } cell_sel_t;

    typedef struct packed {
        logic      load;
        cell_sel_t sel;
    } cell_ctl_t;

    typedef enum logic {
        PQR_IDLE,
        PQR_EXEC
    } pqr_state_t;

endpackage

// ===== rtl/core/pqr_cell.sv =====
// One slot of the sorted queue: holds an entry and its compare flags.
// Depends on pqr_pkg.
module pqr_cell (
    input  logic                     clk,
    input  logic                     capture,
    input  logic [pqr_pkg::KEY_W-1:0] cmp_key,
    input  logic [pqr_pkg::ID_W-1:0]  cmp_id,
    input  pqr_pkg::cell_ctl_t       ctl,
    input  logic [pqr_pkg::KEY_W-1:0] new_key,
    input  logic [pqr_pkg::ID_W-1:0]  new_id,
    input  logic [pqr_pkg::KEY_W-1:0] left_key,
    input  logic [pqr_pkg::ID_W-1:0]  left_id,
    input  logic [pqr_pkg::KEY_W-1:0] right_key,
    input  logic [pqr_pkg::ID_W-1:0]  right_id,
    output logic [pqr_pkg::KEY_W-1:0] key,
    output logic [pqr_pkg::ID_W-1:0]  id,
    output logic                     gt,
    output logic                     hit
);

    logic [pqr_pkg::KEY_W-1:0] key_reg;
    logic [pqr_pkg::KEY_W-1:0] key_next;
    logic [pqr_pkg::ID_W-1:0]  id_reg;
    logic [pqr_pkg::ID_W-1:0]  id_next;
    logic                      gt_reg;
    logic                      hit_reg;

    always_comb
    begin
        unique case (ctl.sel)
            pqr_pkg::SEL_LEFT:
            begin
                key_next = left_key;
                id_next  = left_id;
            end
            pqr_pkg::SEL_RIGHT:
            begin
                key_next = right_key;
                id_next  = right_id;
            end
            default:
            begin
                key_next = new_key;
                id_next  = new_id;
            end
        endcase
    end

    // entry payload and flags: no reset needed, validity comes from the count
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg <= key_next;
            id_reg  <= id_next;
        end
        if (capture)
        begin
            gt_reg  <= (key_reg > cmp_key);
            hit_reg <= (id_reg == cmp_id);
        end
    end

    assign key = key_reg;
    assign id  = id_reg;
    assign gt  = gt_reg;
    assign hit = hit_reg;

endmodule

// ===== rtl/core/priority_ready_queue.sv =====
// Top level of the priority ready queue: control, count and result register.
// Depends on pqr_pkg and pqr_cell.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one command per transaction:
//   enqueue (id, key), dequeue head, or kill by id. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one result per command, in order.
//   Entries sit in a row of cells kept sorted by ascending key; equal keys
//   keep arrival order. Kill removes the first matching id in queue order.
// Timing:
//   At the accept edge every cell registers its key-greater and id-match
//   flags against the incoming command. At the execute edge each cell
//   loads from the new entry, its left or its right neighbor, the count
//   updates and the result is written to the output register.
//   rsp_valid rises at the execute edge; a stall can hold that edge off.
//   A command is not accepted until the one before it has executed, since
//   req_ready is only high between execute and the next accept.
//   A new command is accepted while a result waits in the output register.
// Stall: if rsp is still held when a command reaches execute, execute waits
//   (the cells hold) until the receiver takes the pending result.
// Reset: rst_n (async, active low) empties the queue and drops any result.
//   Slot contents are not cleared; only slots below the count are read.
module priority_ready_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pqr_pkg::pqr_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pqr_pkg::pqr_rsp_t rsp
);

    localparam int D = pqr_pkg::QUEUE_DEPTH;
    localparam int C = pqr_pkg::CNT_W;
    localparam logic [D-1:0] ONE = D'(1);

    pqr_pkg::pqr_state_t state_reg;
    pqr_pkg::pqr_state_t state_next;
    pqr_pkg::pqr_req_t   cmd_reg;
    logic [C-1:0]        count_reg;
    logic [C-1:0]        count_next;
    pqr_pkg::pqr_rsp_t   rsp_reg;
    pqr_pkg::pqr_rsp_t   rsp_next;
    logic                rsp_valid_reg;

    logic accept;
    logic exec_fire;

    logic [pqr_pkg::KEY_W-1:0] cell_key [D];
    logic [pqr_pkg::ID_W-1:0]  cell_id  [D];
    logic [D-1:0]              gt_vec;
    logic [D-1:0]              hit_vec;
    logic [D-1:0]              valid_vec;
    logic [D-1:0]              at_count;
    pqr_pkg::cell_ctl_t        ctl_vec  [D];

    logic [D-1:0] ins_vec;
    logic [D-1:0] match_vec;
    logic [D-1:0] rm_vec;
    logic [D-1:0] first_vec;
    logic         found;
    logic         full;
    logic [pqr_pkg::KEY_W-1:0] sel_key;
    logic [pqr_pkg::ID_W-1:0]  sel_id;

    // ---------------- control FSM ----------------
    always_comb
    begin
        unique case (state_reg)
            pqr_pkg::PQR_IDLE: state_next = accept ? pqr_pkg::PQR_EXEC : pqr_pkg::PQR_IDLE;
            pqr_pkg::PQR_EXEC: state_next = exec_fire ? pqr_pkg::PQR_IDLE : pqr_pkg::PQR_EXEC;
            default:           state_next = pqr_pkg::PQR_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = (state_reg == pqr_pkg::PQR_IDLE);
        exec_fire = (state_reg == pqr_pkg::PQR_EXEC) && (!rsp_valid_reg || rsp_ready);
    end

    assign accept = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pqr_pkg::PQR_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= req;
        if (exec_fire)
            rsp_reg <= rsp_next;
    end

    // ---------------- cell row ----------------
    for (genvar g = 0; g < D; g++)
    begin : g_cell
        logic [pqr_pkg::KEY_W-1:0] lk;
        logic [pqr_pkg::ID_W-1:0]  li;
        logic [pqr_pkg::KEY_W-1:0] rk;
        logic [pqr_pkg::ID_W-1:0]  ri;

        assign valid_vec[g] = (C'(g) < count_reg);
        assign at_count[g]  = (C'(g) == count_reg);

        if (g == 0)
        begin : g_head
            assign lk = cmd_reg.prio_key;
            assign li = cmd_reg.proc_id;
        end
        else
        begin : g_mid
            assign lk = cell_key[g-1];
            assign li = cell_id[g-1];
        end

        if (g == D - 1)
        begin : g_tail
            assign rk = cell_key[g];
            assign ri = cell_id[g];
        end
        else
        begin : g_body
            assign rk = cell_key[g+1];
            assign ri = cell_id[g+1];
        end

        pqr_cell u_cell (
            .clk       (clk),
            .capture   (accept),
            .cmp_key   (req.prio_key),
            .cmp_id    (req.proc_id),
            .ctl       (ctl_vec[g]),
            .new_key   (cmd_reg.prio_key),
            .new_id    (cmd_reg.proc_id),
            .left_key  (lk),
            .left_id   (li),
            .right_key (rk),
            .right_id  (ri),
            .key       (cell_key[g]),
            .id        (cell_id[g]),
            .gt        (gt_vec[g]),
            .hit       (hit_vec[g])
        );
    end

    // ---------------- execute decode ----------------
    // Sorted keys make the greater-than set a suffix of the valid cells:
    // those cells shift right and the first of them takes the new entry.
    assign ins_vec = gt_vec & valid_vec;
    assign full    = (count_reg == C'(D));

    // Dequeue matches the head; kill matches ids. The match vector OR-ed with
    // its two's complement marks every cell from the first match upward.
    assign match_vec = (cmd_reg.command == pqr_pkg::CMD_DEQ) ? (valid_vec & ONE)
                                                              : (hit_vec & valid_vec);
    assign rm_vec    = (match_vec | ((~match_vec) + ONE)) & valid_vec;
    assign first_vec = match_vec & ((~match_vec) + ONE);
    assign found     = |match_vec;

    always_comb
    begin
        sel_key = '0;
        sel_id  = '0;
        for (int i = 0; i < D; i++)
        begin
            sel_key = sel_key | ({pqr_pkg::KEY_W{first_vec[i]}} & cell_key[i]);
            sel_id  = sel_id  | ({pqr_pkg::ID_W{first_vec[i]}}  & cell_id[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            ctl_vec[i].load = 1'b0;
            ctl_vec[i].sel  = pqr_pkg::SEL_NEW;
        end
        count_next           = count_reg;
        rsp_next.status      = pqr_pkg::ST_OK;
        rsp_next.removed_id  = '0;
        rsp_next.removed_key = '0;

        unique case (cmd_reg.command)
            pqr_pkg::CMD_ENQ:
            begin
                if (full)
                begin
                    rsp_next.status = pqr_pkg::ST_FULL;
                end
                else
                begin
                    for (int i = 0; i < D; i++)
                    begin
                        ctl_vec[i].load = exec_fire && (ins_vec[i] || at_count[i]);
                        if (i > 0 && ins_vec[(i > 0) ? i - 1 : 0])
                            ctl_vec[i].sel = pqr_pkg::SEL_LEFT;
                    end
                    count_next = count_reg + C'(1);
                end
            end
            pqr_pkg::CMD_DEQ, pqr_pkg::CMD_KILL:
            begin
                if (found)
                begin
                    for (int i = 0; i < D; i++)
                    begin
                        ctl_vec[i].load = exec_fire && rm_vec[i];
                        ctl_vec[i].sel  = pqr_pkg::SEL_RIGHT;
                    end
                    count_next           = count_reg - C'(1);
                    rsp_next.removed_id  = sel_id;
                    rsp_next.removed_key = sel_key;
                end
                else
                begin
                    rsp_next.status = pqr_pkg::ST_MISS;
                end
            end
            default:
            begin
                // unused code: queue untouched, status ok
            end
        endcase

        rsp_next.queue_empty = (count_next == '0);
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= C'(D))
        else $error("queue count above depth");

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == pqr_pkg::PQR_EXEC))
        else $error("result appeared without an execute cycle");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == pqr_pkg::PQR_EXEC))
        else $error("accepted command did not reach execute");

    a_deq_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && cmd_reg.command == pqr_pkg::CMD_DEQ && count_reg != '0)
        |=> (count_reg == $past(count_reg) - C'(1)))
        else $error("dequeue did not shrink the queue");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> (rsp_reg.queue_empty == (count_reg == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

// ===== dv/tb_priority_ready_queue.sv =====
// Testbench for priority_ready_queue: a directed table followed by random command traffic.
// Every result is checked against a hand-typed value or an in-bench model of the sorted ready queue.
// Depends on pqr_pkg and the priority_ready_queue RTL.
`timescale 1ns / 100ps

module tb_priority_ready_queue;

    localparam int ID_W  = pqr_pkg::ID_W;
    localparam int KEY_W = pqr_pkg::KEY_W;

    // Code 3 is unused by the block: it must leave the queue alone and answer ok.
    localparam logic [1:0] CMD_NOP = 2'd3;

    // Idle chance per cycle on either side, in percent.
    localparam int IDLE_PCT      = 32;
    localparam int RANDOM_ITEMS  = 600;
    // Receiver hold-off length; long enough to back the block up into req_ready.
    localparam int HOLD_CYCLES   = 80;
    localparam int HOLD_AT_ITEM  = 120;
    localparam int PAUSE_AT_ITEM = 300;
    // Stretch of random items with no idling on either side.
    localparam int CALM_FIRST    = 420;
    localparam int CALM_LAST     = 519;
    // Extra wait after the last result, as generous slack before the final verdict.
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200_000;

    // One row of the directed table: the command and, where it is obvious,
    // the result typed in by hand. Other rows use the queue model.
    typedef struct packed {
        pqr_pkg::pqr_req_t cmd;
        logic              typed;
        pqr_pkg::pqr_rsp_t rsp;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    pqr_pkg::pqr_req_t req;
    logic              rsp_valid;
    logic              rsp_ready;
    pqr_pkg::pqr_rsp_t rsp;

    // Model of the queue contents, position 0 is the head.
    logic [KEY_W-1:0] ready_keys[$];
    logic [ID_W-1:0]  ready_ids[$];

    // Results still owed by the block, oldest first.
    pqr_pkg::pqr_rsp_t pending_results[$];
    stim_row_t         directed_rows[$];

    int  fail_count  = 0;
    int  cycle_count = 0;
    // Set by the sender to start the receiver's long hold-off.
    bit  hold_request = 1'b0;
    // No idling on either side while set.
    bit  calm = 1'b0;

    priority_ready_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the queue model and return the result it owes.
    // Enqueue goes in front of the first strictly greater key, so equal keys
    // keep arrival order; kill takes the first matching id from the head.
    function automatic pqr_pkg::pqr_rsp_t apply_queue_command(input pqr_pkg::pqr_req_t c);
        pqr_pkg::pqr_rsp_t res;
        int                pos;
        int                i;
        bit                found;
        res        = '0;
        res.status = pqr_pkg::ST_OK;
        pos        = ready_keys.size();
        found      = 1'b0;
        case (c.command)
            pqr_pkg::CMD_ENQ:
            begin
                if (ready_keys.size() >= pqr_pkg::QUEUE_DEPTH)
                    res.status = pqr_pkg::ST_FULL;
                else
                begin
                    for (i = 0; i < ready_keys.size(); i++)
                    begin
                        if (!found && ready_keys[i] > c.prio_key)
                        begin
                            pos   = i;
                            found = 1'b1;
                        end
                    end
                    ready_keys.insert(pos, c.prio_key);
                    ready_ids.insert(pos, c.proc_id);
                end
            end
            pqr_pkg::CMD_DEQ:
            begin
                if (ready_keys.size() == 0)
                    res.status = pqr_pkg::ST_MISS;
                else
                begin
                    res.removed_id  = ready_ids.pop_front();
                    res.removed_key = ready_keys.pop_front();
                end
            end
            pqr_pkg::CMD_KILL:
            begin
                for (i = 0; i < ready_ids.size(); i++)
                begin
                    if (!found && ready_ids[i] == c.proc_id)
                    begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                    res.status = pqr_pkg::ST_MISS;
                else
                begin
                    res.removed_id  = ready_ids[pos];
                    res.removed_key = ready_keys[pos];
                    ready_ids.delete(pos);
                    ready_keys.delete(pos);
                end
            end
            default:
            begin
                // unused code: nothing changes
            end
        endcase
        res.queue_empty = (ready_keys.size() == 0);
        return res;
    endfunction

    // Random command whose mix depends on the phase: 0 fills, 1 balances,
    // 2 drains. Kill mostly aims at a live id so it gets past the miss path.
    function automatic pqr_pkg::pqr_req_t random_command(input int phase);
        pqr_pkg::pqr_req_t c;
        int                enq_pct;
        int                pick;
        enq_pct   = (phase == 0) ? 70 : (phase == 1) ? 45 : 20;
        pick      = $urandom_range(0, 99);
        // Small id pool gives duplicate ids; the rest spans every bit.
        c.proc_id = ($urandom_range(0, 99) < 60) ? ID_W'($urandom_range(0, 7))
                                                 : ID_W'($urandom);
        case ($urandom_range(0, 9))
            0:       c.prio_key = '0;
            1:       c.prio_key = '1;
            2, 3, 4, 5:
                     c.prio_key = {16'($urandom_range(0, 7)), 16'h0000};
            default: c.prio_key = $urandom;
        endcase
        if (pick < 3)
            c.command = CMD_NOP;
        else if (pick < 3 + enq_pct)
            c.command = pqr_pkg::CMD_ENQ;
        else if (pick % 2)
            c.command = pqr_pkg::CMD_DEQ;
        else
        begin
            c.command = pqr_pkg::CMD_KILL;
            if (ready_ids.size() != 0 && $urandom_range(0, 99) < 80)
                c.proc_id = ready_ids[$urandom_range(0, ready_ids.size() - 1)];
        end
        return c;
    endfunction

    task automatic add_row(input logic [1:0] command, input logic [ID_W-1:0] id,
                           input logic [KEY_W-1:0] key, input logic typed,
                           input logic [1:0] status, input logic [ID_W-1:0] rid,
                           input logic [KEY_W-1:0] rkey, input logic empty);
        stim_row_t row;
        row.cmd.command      = command;
        row.cmd.proc_id      = id;
        row.cmd.prio_key     = key;
        row.typed            = typed;
        row.rsp.status       = status;
        row.rsp.removed_id   = rid;
        row.rsp.removed_key  = rkey;
        row.rsp.queue_empty  = empty;
        directed_rows.push_back(row);
    endtask

    // Offer one transaction, with random idle cycles in front of it, and hold
    // it until accepted. Valid stays high on return so back-to-back
    // transactions need no extra assignment in the same step.
    task automatic send_command(input pqr_pkg::pqr_req_t c, input logic typed,
                                input pqr_pkg::pqr_rsp_t typed_rsp);
        pqr_pkg::pqr_rsp_t model_rsp;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= c;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        model_rsp = apply_queue_command(c);
        pending_results.push_back(typed ? typed_rsp : model_rsp);
    endtask

    task automatic check_result(input pqr_pkg::pqr_rsp_t got);
        pqr_pkg::pqr_rsp_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: status %0d id %h key %h empty %0d",
                   got.status, got.removed_id, got.removed_key, got.queue_empty);
            fail_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_count++;
            end
            if (got.removed_id !== want.removed_id)
            begin
                $error("removed_id: expected %h, got %h", want.removed_id, got.removed_id);
                fail_count++;
            end
            if (got.removed_key !== want.removed_key)
            begin
                $error("removed_key: expected %h, got %h", want.removed_key,
                       got.removed_key);
                fail_count++;
            end
            if (got.queue_empty !== want.queue_empty)
            begin
                $error("queue_empty: expected %0d, got %0d", want.queue_empty,
                       got.queue_empty);
                fail_count++;
            end
        end
    endtask

    // Receiver: takes results, idles at random, and on request holds off for
    // a long stretch so the block fills its pipeline and drops req_ready.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
                check_result(rsp);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: a hung handshake or a missing result ends here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Sender and sequence control.
    initial
    begin
        pqr_pkg::pqr_req_t c;
        int                n;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;

        // Directed table. Empty-queue misses and the unused code first, then
        // sixteen enqueues that fill the queue with extreme ids and keys,
        // equal keys and a duplicate id, then the full, absent-id and
        // first-match cases.
        add_row(pqr_pkg::CMD_DEQ,  16'h0000, 32'h0000_0000, 1'b1, pqr_pkg::ST_MISS,
                '0, '0, 1'b1);
        add_row(pqr_pkg::CMD_KILL, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, pqr_pkg::ST_MISS,
                '0, '0, 1'b1);
        add_row(CMD_NOP,           16'hFFFF, 32'hFFFF_FFFF, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b1);
        add_row(pqr_pkg::CMD_ENQ,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h0000, 32'h0000_0000, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h0005, 32'h0001_8000, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h0005, 32'h0001_8000, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h1234, 32'h0001_0000, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h00A0, 32'h0001_8000, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h8000, 32'h8000_0000, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h7FFF, 32'h7FFF_FFFF, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h0001, 32'h0000_0000, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h0002, 32'hFFFF_FFFF, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h0003, 32'h0002_0000, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h0004, 32'h0000_0001, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h5555, 32'h5555_5555, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'hAAAA, 32'hAAAA_AAAA, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h0006, 32'h0003_0000, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_ENQ,  16'h0007, 32'h0000_FFFF, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        // queue now full: this one is dropped
        add_row(pqr_pkg::CMD_ENQ,  16'h0008, 32'h0000_0000, 1'b1, pqr_pkg::ST_FULL,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_KILL, 16'h0BAD, 32'h0000_0000, 1'b1, pqr_pkg::ST_MISS,
                '0, '0, 1'b0);
        // duplicate id: first match in queue order goes
        add_row(pqr_pkg::CMD_KILL, 16'h0005, 32'h0000_0000, 1'b0, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        // head is the earlier of the two zero keys
        add_row(pqr_pkg::CMD_DEQ,  16'h0000, 32'h0000_0000, 1'b0, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(CMD_NOP,           16'h0000, 32'h0000_0000, 1'b1, pqr_pkg::ST_OK,
                '0, '0, 1'b0);
        add_row(pqr_pkg::CMD_KILL, 16'hFFFF, 32'h0000_0000, 1'b0, pqr_pkg::ST_OK,
                '0, '0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_command(directed_rows[k].cmd, directed_rows[k].typed,
                         directed_rows[k].rsp);

        // Random traffic in fill / balance / drain phases of 40 transactions.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == HOLD_AT_ITEM)
                hold_request = 1'b1;
            // Sender pause: drain everything before going on.
            if (n == PAUSE_AT_ITEM)
            begin
                req_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            calm = (n >= CALM_FIRST && n <= CALM_LAST);
            c    = random_command((n / 40) % 3);
            send_command(c, 1'b0, '0);
        end

        req_valid <= 1'b0;
        calm = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pqr_pkg.sv
rtl/core/pqr_cell.sv
rtl/core/priority_ready_queue.sv
dv/tb_priority_ready_queue.sv
